// ===== design/two_by_two_kernel_bloch_angles_core_defines.svh =====
// Assertion macros for the Bloch angle kernel checker
`ifndef TWO_BY_TWO_KERNEL_BLOCH_ANGLES_CORE_DEFINES_SVH
`define TWO_BY_TWO_KERNEL_BLOCH_ANGLES_CORE_DEFINES_SVH
// same-cycle implication
`define BKA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BKA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/bka_pkg.sv =====
// Types, constants and the arctangent table of the Bloch angle kernel
package bka_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int THETA_W  = 15;
  localparam int STEPS    = 31;
  localparam int DP_W     = 40;
  localparam int TURN_W   = 32;
  localparam int Z_W      = 33;
  localparam logic [31:0] GAIN_Q30  = 32'd1768195363;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] TQ3_TURN  = 32'hC000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] up_top_re;
    logic signed [SAMPLE_W-1:0] up_top_im;
    logic signed [SAMPLE_W-1:0] up_bottom_re;
    logic signed [SAMPLE_W-1:0] up_bottom_im;
    logic signed [SAMPLE_W-1:0] down_top_re;
    logic signed [SAMPLE_W-1:0] down_top_im;
    logic signed [SAMPLE_W-1:0] down_bottom_re;
    logic signed [SAMPLE_W-1:0] down_bottom_im;
  } in_t;

  typedef struct packed {
    logic [THETA_W-1:0] polar_up;
    logic [ANGLE_W-1:0] phi_up;
    logic [THETA_W-1:0] polar_down;
    logic [ANGLE_W-1:0] phi_down;
  } out_t;

  typedef struct packed {
    logic                  nz;
    logic                  zneg;
    logic                  rz;
    logic [TURN_W-1:0]     pa;
    logic signed [Z_W-1:0] zv;
  } side_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/bka_cordic.sv =====
// Pipelined CORDIC vectoring unit, one rotation per stage
module bka_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_in,
  input  logic signed [bka_pkg::DP_W-1:0]   x_in,
  input  logic signed [bka_pkg::DP_W-1:0]   y_in,
  input  bka_pkg::side_t                    side_in,
  output logic                              vld_out,
  output logic signed [bka_pkg::DP_W-1:0]   x_out,
  output logic [bka_pkg::TURN_W-1:0]        z_out,
  output bka_pkg::side_t                    side_out
);

  localparam int N = bka_pkg::STEPS;

  logic signed [bka_pkg::DP_W-1:0] x_r [0:N];
  logic signed [bka_pkg::DP_W-1:0] y_r [0:N];
  logic [bka_pkg::TURN_W-1:0]      z_r [0:N];
  bka_pkg::side_t                  s_r [0:N];
  logic                            v_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= side_in;
      if (x_in[bka_pkg::DP_W-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= bka_pkg::HALF_TURN;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [bka_pkg::DP_W-1:0] dx;
    logic signed [bka_pkg::DP_W-1:0] dy;
    logic [bka_pkg::TURN_W-1:0]      ang;
    logic                            pos;

    assign dx  = y_r[k] >>> k;
    assign dy  = x_r[k] >>> k;
    assign ang = bka_pkg::atan_lut(5'(k));
    assign pos = !y_r[k][bka_pkg::DP_W-1] && (y_r[k] != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1] <= s_r[k];
        if (pos) begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + ang;
        end else begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - ang;
        end
      end
    end
  end

  assign vld_out  = v_r[N];
  assign x_out    = x_r[N];
  assign z_out    = z_r[N];
  assign side_out = s_r[N];

endmodule

// ===== design/bka_lane.sv =====
// One column lane: Pauli values, phase vectoring, gain multiply, polar vectoring, rounding
module bka_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_in,
  input  logic signed [bka_pkg::SAMPLE_W-1:0] ar,
  input  logic signed [bka_pkg::SAMPLE_W-1:0] ai,
  input  logic signed [bka_pkg::SAMPLE_W-1:0] br,
  input  logic signed [bka_pkg::SAMPLE_W-1:0] bi,
  output logic                                vld_out,
  output logic [bka_pkg::THETA_W-1:0]         theta,
  output logic [bka_pkg::ANGLE_W-1:0]         phi
);

  localparam int DW = bka_pkg::DP_W;
  localparam int PW = 2 * bka_pkg::SAMPLE_W;
  localparam int MW = 48;

  logic signed [PW-1:0] aa_r, ii_r, bb_r, jj_r, arbr_r, aibi_r, arbi_r, aibr_r;
  logic                 pv_r;
  logic signed [DW-1:0] zs_r, xs_r, ys_r;
  logic                 sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (en) begin
      pv_r <= vld_in;
      sv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r   <= ar * ar;
      ii_r   <= ai * ai;
      bb_r   <= br * br;
      jj_r   <= bi * bi;
      arbr_r <= ar * br;
      aibi_r <= ai * bi;
      arbi_r <= ar * bi;
      aibr_r <= ai * br;
      zs_r   <= DW'(aa_r) + DW'(ii_r) - DW'(bb_r) - DW'(jj_r);
      xs_r   <= (DW'(arbr_r) + DW'(aibi_r)) <<< 1;
      ys_r   <= (DW'(arbi_r) - DW'(aibr_r)) <<< 1;
    end
  end

  bka_pkg::side_t side1_in, side1_out, side2_in, side2_out;
  logic signed [DW-1:0] x1, x2;
  logic [bka_pkg::TURN_W-1:0] z1, z2;
  logic v1, v2;

  always_comb begin
    side1_in      = '0;
    side1_in.nz   = (xs_r != '0) || (ys_r != '0);
    side1_in.zneg = zs_r[DW-1];
    side1_in.zv   = zs_r[bka_pkg::Z_W-1:0];
  end

  bka_cordic u_phase (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(sv_r),
    .x_in(xs_r), .y_in(ys_r), .side_in(side1_in),
    .vld_out(v1), .x_out(x1), .z_out(z1), .side_out(side1_out)
  );

  logic signed [MW-1:0] plo_r, phi_r;
  logic signed [DW-1:0] r_a_r, r_b_r, zk_b_r;
  bka_pkg::side_t       side_a, s_a_r, s_b_r;
  logic                 va_r, vb_r;
  logic [15:0]          zl;
  logic signed [16:0]   zh;
  logic signed [16:0]   zl_s;
  logic signed [32:0]   g_s;
  logic signed [63:0]   full;

  assign zl   = side1_out.zv[15:0];
  assign zh   = side1_out.zv[bka_pkg::Z_W-1:16];
  assign zl_s = $signed({1'b0, zl});
  assign g_s  = $signed({1'b0, bka_pkg::GAIN_Q30});
  assign full = (64'(phi_r) <<< 16) + 64'(plo_r);

  always_comb begin
    side_a    = side1_out;
    side_a.pa = side1_out.nz ? z1 : '0;
    side_a.rz = !side1_out.nz || (x1 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v1;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r      <= MW'(zl_s * g_s);
      phi_r      <= MW'(zh * g_s);
      s_a_r      <= side_a;
      r_a_r      <= side1_out.nz ? x1 : '0;
      s_b_r      <= s_a_r;
      r_b_r      <= r_a_r;
      zk_b_r     <= DW'(full >>> 30);
    end
  end

  assign side2_in = s_b_r;

  bka_cordic u_polar (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vb_r),
    .x_in(zk_b_r), .y_in(r_b_r), .side_in(side2_in),
    .vld_out(v2), .x_out(x2), .z_out(z2), .side_out(side2_out)
  );

  logic [bka_pkg::TURN_W-1:0] t;
  logic [bka_pkg::TURN_W:0]   t_rnd;
  logic [bka_pkg::TURN_W:0]   p_rnd;
  logic                       vo_r;
  logic [bka_pkg::THETA_W-1:0] theta_r;
  logic [bka_pkg::ANGLE_W-1:0] phi_o_r;

  always_comb begin
    if (side2_out.rz) begin
      t = side2_out.zneg ? bka_pkg::HALF_TURN : '0;
    end else if (z2 >= bka_pkg::TQ3_TURN) begin
      t = '0;
    end else if (z2 > bka_pkg::HALF_TURN) begin
      t = bka_pkg::HALF_TURN;
    end else begin
      t = z2;
    end
    t_rnd = {1'b0, t} + 33'(1 << (bka_pkg::TURN_W - bka_pkg::ANGLE_W));
    p_rnd = {1'b0, side2_out.pa} + 33'(1 << (bka_pkg::TURN_W - bka_pkg::ANGLE_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= t_rnd[bka_pkg::TURN_W-bka_pkg::ANGLE_W+1 +: bka_pkg::THETA_W];
      phi_o_r <= p_rnd[bka_pkg::TURN_W-bka_pkg::ANGLE_W +: bka_pkg::ANGLE_W];
    end
  end

  assign vld_out = vo_r;
  assign theta   = theta_r;
  assign phi     = phi_o_r;

  logic unused_ok;
  assign unused_ok = ^x2;

endmodule

// ===== design/two_by_two_kernel_bloch_angles_core.sv =====
// Top level of the Bloch angle kernel: two column lanes and the merging output stage
// Takes one 2x2 kernel per cycle while not stalled and returns polar and phase angles
// for both columns. Each column runs in its own lane: products, Pauli sums, a 32-stage
// CORDIC for the phase (a half-turn pre-rotation and 31 rotations), a split gain multiply
// in product and scaling registers, a second 32-stage CORDIC for the polar angle and a
// rounding stage; the merge register then offsets the second column. A request passes
// 70 register stages; throughput is one kernel per cycle, and the whole pipeline holds
// while a result waits under out_stall.
module two_by_two_kernel_bloch_angles_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bka_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bka_pkg::out_t  out_data
);

  logic adv;
  logic up_v, dn_v;
  logic [bka_pkg::THETA_W-1:0] th_up, th_dn;
  logic [bka_pkg::ANGLE_W-1:0] ph_up, ph_dn;
  logic out_valid_r;
  bka_pkg::out_t out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  bka_lane u_up (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(in_valid),
    .ar(in_data.up_top_re), .ai(in_data.up_top_im),
    .br(in_data.up_bottom_re), .bi(in_data.up_bottom_im),
    .vld_out(up_v), .theta(th_up), .phi(ph_up)
  );

  bka_lane u_down (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(in_valid),
    .ar(in_data.down_top_re), .ai(in_data.down_top_im),
    .br(in_data.down_bottom_re), .bi(in_data.down_bottom_im),
    .vld_out(dn_v), .theta(th_dn), .phi(ph_dn)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= up_v && dn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.polar_up   <= th_up;
      out_data_r.phi_up     <= ph_up;
      out_data_r.polar_down <= bka_pkg::THETA_W'(1 << (bka_pkg::ANGLE_W - 2)) - th_dn;
      out_data_r.phi_down   <= ph_dn + bka_pkg::ANGLE_W'(1 << (bka_pkg::ANGLE_W - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bka_checker.sv =====
// Port-level checker for the Bloch angle kernel and its bind
`include "two_by_two_kernel_bloch_angles_core_defines.svh"
module bka_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input bka_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input bka_pkg::out_t out_data
);

  `BKA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `BKA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `BKA_ASSERT_NOW(a_polar_range, out_valid, (out_data.polar_up <= 15'd16384) && (out_data.polar_down <= 15'd16384))
  `BKA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `BKA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind two_by_two_kernel_bloch_angles_core bka_checker u_bka_checker (.*);
